[sv/crr_pkg.sv]
// ----------------------------------------------------------------------------
// crr_pkg
// Shared types and constants for the cascaded range remap block.
// ----------------------------------------------------------------------------
package crr_pkg;

    localparam int FIELD_W = 32;
    localparam int OP_W    = 2;
    localparam int STAGE_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_XLATE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic {
        SC_IDLE = 1'b0,
        SC_SCAN = 1'b1
    } t_scan_state;

    // Handshake from the scanner back to the control logic.
    typedef struct packed {
        logic busy;
        logic done;
    } t_scan_stat;

endpackage

[sv/crr_if.sv]
// ----------------------------------------------------------------------------
// crr_in_if / crr_out_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface crr_in_if
    import crr_pkg::*;
();
    logic               valid;
    logic               ready;
    t_op                op;
    logic [STAGE_W-1:0] stage;
    logic [FIELD_W-1:0] dest_start;
    logic [FIELD_W-1:0] source_start;
    logic [FIELD_W-1:0] range_length;
    logic [FIELD_W-1:0] seed_value;

    modport source (
        output valid, op, stage, dest_start, source_start, range_length, seed_value,
        input  ready
    );
    modport sink (
        input  valid, op, stage, dest_start, source_start, range_length, seed_value,
        output ready
    );
endinterface

interface crr_out_if
    import crr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] final_value;
    logic [FIELD_W-1:0] lowest_value;
    logic               status;

    modport source (
        output valid, final_value, lowest_value, status,
        input  ready
    );
    modport sink (
        input  valid, final_value, lowest_value, status,
        output ready
    );
endinterface

[sv/crr_entry_mem.sv]
// ----------------------------------------------------------------------------
// crr_entry_mem
// Range entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module crr_entry_mem #(
    parameter int DEPTH  = 448,
    parameter int DATA_W = 96,
    parameter int ADDR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[sv/crr_scan.sv]
// ----------------------------------------------------------------------------
// crr_scan
// Walks the stage tables newest entry first, one memory read per cycle
// within a stage, and remaps the value on the first hit in each stage.
// ----------------------------------------------------------------------------
module crr_scan
    import crr_pkg::*;
#(
    parameter int NUM_STAGES        = 7,
    parameter int ENTRIES_PER_STAGE = 64,
    parameter int VALUE_BITS        = 32,
    parameter int ADDR_W            = 9,
    parameter int FILL_W            = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [VALUE_BITS-1:0]               i_seed,
    input  logic [NUM_STAGES-1:0][FILL_W-1:0]   i_fill,
    output logic                                o_rd_en,
    output logic [ADDR_W-1:0]                   o_rd_addr,
    input  logic [3*VALUE_BITS-1:0]             i_rd_data,
    output t_scan_stat                          o_stat,
    output logic [VALUE_BITS-1:0]               o_result
);

    localparam int STG_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

    t_scan_state                     r_state, n_state;
    logic [STG_W-1:0]                r_stage;
    logic [ADDR_W-1:0]               r_base;
    logic [FILL_W-1:0]               r_left;
    logic                            r_pend;
    logic [VALUE_BITS-1:0]           r_value;
    logic [NUM_STAGES:0][FILL_W-1:0] r_fills;
    logic [NUM_STAGES:0][FILL_W-1:0] w_fills_shift;

    logic [VALUE_BITS-1:0] w_dst, w_src, w_len, w_diff, w_mapped;
    logic                  w_hit, w_issue, w_stage_end, w_last, w_done;

    assign w_dst = i_rd_data[3*VALUE_BITS-1:2*VALUE_BITS];
    assign w_src = i_rd_data[2*VALUE_BITS-1:VALUE_BITS];
    assign w_len = i_rd_data[VALUE_BITS-1:0];

    // Exact range test, no wrap: v >= src and v - src < len.
    assign w_diff   = r_value - w_src;
    assign w_hit    = r_pend && (r_value >= w_src) && (w_diff < w_len);
    assign w_mapped = w_dst + w_diff;

    // stage ends on a hit, or when no entry is left to read (an empty stage issues no read)
    assign w_stage_end   = w_hit || (r_left == '0);
    assign w_last        = (r_stage == STG_W'(NUM_STAGES - 1));
    assign w_fills_shift = r_fills >> FILL_W;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SC_IDLE: if (i_start) n_state = SC_SCAN;
            SC_SCAN: if (w_stage_end && w_last) n_state = SC_IDLE;
            default: n_state = SC_IDLE;
        endcase
    end

    always_comb begin
        w_issue = 1'b0;
        w_done  = 1'b0;
        unique case (r_state)
            SC_IDLE: begin
                w_issue = 1'b0;
                w_done  = 1'b0;
            end
            SC_SCAN: begin
                // a hit ends the stage, so no further read is launched
                w_issue = !w_hit && (r_left != '0);
                w_done  = w_stage_end && w_last;
            end
            default: begin
                w_issue = 1'b0;
                w_done  = 1'b0;
            end
        endcase
    end

    assign o_rd_en     = w_issue;
    assign o_rd_addr   = r_base + ADDR_W'(r_left - FILL_W'(1));
    assign o_stat.busy = (r_state == SC_SCAN);
    assign o_stat.done = w_done;
    assign o_result    = w_hit ? w_mapped : r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_pend  <= 1'b0;
            r_left  <= '0;
            r_stage <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == SC_IDLE) begin
                r_pend <= 1'b0;
                if (i_start) begin
                    r_value <= i_seed;
                    r_fills <= {FILL_W'(0), i_fill};
                    r_left  <= i_fill[0];
                    r_stage <= '0;
                    r_base  <= '0;
                end
            end else if (w_stage_end) begin
                r_pend <= 1'b0;
                if (w_hit) begin
                    r_value <= w_mapped;
                end
                if (!w_last) begin
                    r_stage <= r_stage + STG_W'(1);
                    r_base  <= r_base + ADDR_W'(ENTRIES_PER_STAGE);
                    r_fills <= w_fills_shift;
                    r_left  <= w_fills_shift[0];
                end
            end else begin
                r_pend <= w_issue;
                if (w_issue) begin
                    r_left <= r_left - FILL_W'(1);
                end
            end
        end
    end

    a_read_only_scanning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (r_state == SC_SCAN))
        else $error("entry read outside a scan");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == SC_IDLE))
        else $error("scan started while busy");

    a_read_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && !w_done) |=> r_pend)
        else $error("issued read not tracked");

endmodule

[sv/cascaded_range_remap_min.sv]
// ----------------------------------------------------------------------------
// cascaded_range_remap_min
// Cascaded range remap tables with running minimum of translated values.
// ----------------------------------------------------------------------------
//  Channel | Dir | Transaction
//  i_in    | in  | op, stage, dest_start, source_start, range_length, seed_value
//  o_out   | out | final_value, lowest_value, status
//
//  Load, clear and unused-op results are registered and show on o_out the
//  next cycle.
//  Translate walks each stage through the single read port of the entry
//  memory, newest entry first; a stage ends at its first hit or once all of
//  its entries have been read.
//  One transaction is in work at a time; i_in.ready drops during a scan and
//  while a result is held by o_out.ready low. Reset clears fill counts and
//  the minimum; the entry memory itself is never cleared.
// ----------------------------------------------------------------------------
module cascaded_range_remap_min
    import crr_pkg::*;
#(
    parameter int NUM_STAGES        = 7,
    parameter int ENTRIES_PER_STAGE = 64,
    parameter int VALUE_BITS        = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crr_in_if.sink    i_in,
    crr_out_if.source o_out
);

    localparam int TOTAL  = NUM_STAGES * ENTRIES_PER_STAGE;
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int FILL_W = $clog2(ENTRIES_PER_STAGE + 1);
    localparam int DATA_W = 3 * VALUE_BITS;

    logic [NUM_STAGES-1:0][FILL_W-1:0] r_fill;
    logic [VALUE_BITS-1:0]             r_min;
    logic                              r_busy;
    logic                              r_out_vld;
    logic [FIELD_W-1:0]                r_final;
    logic [FIELD_W-1:0]                r_lowest;
    logic                              r_status;

    logic                  w_acc, w_stage_ok, w_load_ok, w_we, w_start;
    logic [FILL_W-1:0]     w_sel_fill;
    logic [ADDR_W-1:0]     w_waddr, w_raddr;
    logic [DATA_W-1:0]     w_wdata, w_rdata;
    logic                  w_re;
    t_scan_stat            w_scan;
    logic [VALUE_BITS-1:0] w_result, w_new_min;

    assign i_in.ready = !r_busy && (!r_out_vld || o_out.ready);
    assign w_acc      = i_in.valid && i_in.ready;

    always_comb begin
        w_sel_fill = '0;
        for (int i = 0; i < NUM_STAGES; i++) begin
            if ({2'b00, i_in.stage} == 5'(i)) begin
                w_sel_fill = r_fill[i];
            end
        end
    end

    assign w_stage_ok = ({2'b00, i_in.stage} < 5'(NUM_STAGES));
    assign w_load_ok  = w_stage_ok && (w_sel_fill < FILL_W'(ENTRIES_PER_STAGE));
    assign w_we       = w_acc && (i_in.op == OP_LOAD) && w_load_ok;
    assign w_start    = w_acc && (i_in.op == OP_XLATE);
    assign w_waddr    = ADDR_W'(i_in.stage) * ADDR_W'(ENTRIES_PER_STAGE)
                        + ADDR_W'(w_sel_fill);
    assign w_wdata    = {VALUE_BITS'(i_in.dest_start), VALUE_BITS'(i_in.source_start),
                         VALUE_BITS'(i_in.range_length)};

    crr_entry_mem #(
        .DEPTH  (TOTAL),
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    crr_scan #(
        .NUM_STAGES        (NUM_STAGES),
        .ENTRIES_PER_STAGE (ENTRIES_PER_STAGE),
        .VALUE_BITS        (VALUE_BITS),
        .ADDR_W            (ADDR_W),
        .FILL_W            (FILL_W)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_seed    (VALUE_BITS'(i_in.seed_value)),
        .i_fill    (r_fill),
        .o_rd_en   (w_re),
        .o_rd_addr (w_raddr),
        .i_rd_data (w_rdata),
        .o_stat    (w_scan),
        .o_result  (w_result)
    );

    assign w_new_min = (w_result < r_min) ? w_result : r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_acc && (i_in.op == OP_CLEAR)) begin
            r_fill <= '0;
        end else begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                if (w_we && ({2'b00, i_in.stage} == 5'(i))) begin
                    r_fill[i] <= r_fill[i] + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= '1;
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_scan.done) begin
                r_busy    <= 1'b0;
                r_min     <= w_new_min;
                r_out_vld <= 1'b1;
                r_final   <= FIELD_W'(w_result);
                r_lowest  <= FIELD_W'(w_new_min);
                r_status  <= STATUS_OK;
            end else if (w_acc) begin
                case (i_in.op)
                    OP_XLATE: begin
                        r_busy    <= 1'b1;
                        r_out_vld <= 1'b0;
                    end
                    OP_CLEAR: begin
                        r_min     <= '1;
                        r_out_vld <= 1'b1;
                        r_final   <= '0;
                        r_lowest  <= FIELD_W'({VALUE_BITS{1'b1}});
                        r_status  <= STATUS_OK;
                    end
                    OP_LOAD: begin
                        r_out_vld <= 1'b1;
                        r_final   <= '0;
                        r_lowest  <= FIELD_W'(r_min);
                        r_status  <= w_load_ok ? STATUS_OK : STATUS_FULL;
                    end
                    default: begin
                        r_out_vld <= 1'b1;
                        r_final   <= '0;
                        r_lowest  <= FIELD_W'(r_min);
                        r_status  <= STATUS_OK;
                    end
                endcase
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.final_value  = r_final;
    assign o_out.lowest_value = r_lowest;
    assign o_out.status       = r_status;

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !w_we)
        else $error("entry write during a scan");

    a_done_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan.done |-> r_busy)
        else $error("scan result without a pending translate");

    a_slot_free_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan.done |-> !r_out_vld)
        else $error("translate result would overwrite a held result");

    a_busy_tracks_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_busy && w_scan.busy))
        else $error("translate accepted but scan not running");

endmodule

[verif/tb_cascaded_range_remap_min.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cascaded_range_remap_min
// Self-checking bench for the cascaded range remap block: a short table of
// directed transactions, a stage filled past capacity, then random loads,
// translates, clears and unused ops with chained ranges. A scoreboard predicts results
// the table does not give; results see random backpressure, requests gaps.
// ----------------------------------------------------------------------------
module tb_cascaded_range_remap_min;
    import crr_pkg::*;

    localparam int NUM_ST     = 7;
    localparam int DEPTH      = 64;
    localparam int RAND_N     = 1800;
    localparam int HOLD_CYC   = 400;
    localparam int MAX_CYCLES = 5_000_000;
    localparam int DIR_N      = 23;

    localparam logic [FIELD_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        t_op                op;
        logic [STAGE_W-1:0] stage;
        logic [FIELD_W-1:0] dst;
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] seed;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] final_value;
        logic [FIELD_W-1:0] lowest_value;
        logic               status;
    } t_res;

    typedef struct packed {
        t_req req;
        logic chk;
        t_res res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    crr_in_if  req_if ();
    crr_out_if res_if ();

    cascaded_range_remap_min u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // Scoreboard copy of the block state
    logic [FIELD_W-1:0] tab_dst [NUM_ST][DEPTH];
    logic [FIELD_W-1:0] tab_src [NUM_ST][DEPTH];
    logic [FIELD_W-1:0] tab_len [NUM_ST][DEPTH];
    int                 fill_cnt [NUM_ST];
    logic [FIELD_W-1:0] low_min;

    t_res     pending_res_q [$];
    t_dir_row dir_tab [DIR_N];
    int       err_cnt  = 0;
    int       cyc_cnt  = 0;
    bit       idle_en  = 1'b0;
    bit       hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > MAX_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                   input logic [FIELD_W-1:0] want);
        err_cnt++;
        $display("MISMATCH %s: got %h want %h (cycle %0d)", what, got, want, cyc_cnt);
    endtask

    // Applies one transaction to the scoreboard state and returns its result.
    function automatic t_res remap_predict(input t_req r);
        t_res               o;
        logic [FIELD_W-1:0] v;
        logic [FIELD_W-1:0] nv;
        bit                 hit;
        o.final_value = '0;
        o.status      = STATUS_OK;
        case (r.op)
            OP_LOAD: begin
                if (r.stage >= NUM_ST || fill_cnt[r.stage] >= DEPTH) begin
                    o.status = STATUS_FULL;
                end else begin
                    tab_dst[r.stage][fill_cnt[r.stage]] = r.dst;
                    tab_src[r.stage][fill_cnt[r.stage]] = r.src;
                    tab_len[r.stage][fill_cnt[r.stage]] = r.len;
                    fill_cnt[r.stage]++;
                end
            end
            OP_XLATE: begin
                v = r.seed;
                for (int s = 0; s < NUM_ST; s++) begin
                    hit = 1'b0;
                    nv  = v;
                    // newest entry wins, so walk the table from the top
                    for (int k = fill_cnt[s] - 1; k >= 0 && !hit; k--) begin
                        if (v >= tab_src[s][k] && (v - tab_src[s][k]) < tab_len[s][k]) begin
                            nv  = tab_dst[s][k] + (v - tab_src[s][k]);
                            hit = 1'b1;
                        end
                    end
                    v = nv;
                end
                if (v < low_min)
                    low_min = v;
                o.final_value = v;
            end
            OP_CLEAR: begin
                for (int s = 0; s < NUM_ST; s++)
                    fill_cnt[s] = 0;
                low_min = ALL_ONES;
            end
            default: ;
        endcase
        o.lowest_value = low_min;
        return o;
    endfunction

    // Random transaction; mostly loads and translates aimed at loaded ranges.
    function automatic t_req gen_req(input logic [STAGE_W-1:0] hot);
        t_req               r;
        int                 pick;
        int                 s;
        int                 k;
        logic [FIELD_W-1:0] off;
        r.op    = OP_XLATE;
        r.stage = STAGE_W'($urandom);
        r.dst   = $urandom;
        r.src   = $urandom;
        r.len   = $urandom;
        r.seed  = $urandom;
        pick    = $urandom_range(0, 99);
        if (pick < 1) begin
            r.op = OP_CLEAR;
        end else if (pick < 3) begin
            r.op = OP_NONE;
        end else if (pick < 50) begin
            r.op = OP_LOAD;
            if ($urandom_range(0, 1) == 0)
                r.stage = hot;
            case ($urandom_range(0, 9))
                0:          r.len = '0;
                1, 2:       ;
                3, 4, 5, 6: r.len = $urandom_range(1, 16);
                default:    r.len = $urandom_range(0, 65535);
            endcase
            if ($urandom_range(0, 9) == 0)
                r.dst = ALL_ONES - $urandom_range(0, 255);
            s = int'(r.stage);
            // chain into the previous stage's output ranges
            if (s > 0 && s < NUM_ST && fill_cnt[s-1] != 0 && $urandom_range(0, 1) == 1) begin
                k     = $urandom_range(0, fill_cnt[s-1] - 1);
                r.src = tab_dst[s-1][k] + $urandom_range(0, 8);
            end else if ($urandom_range(0, 9) == 0) begin
                r.src = '0;
            end else if ($urandom_range(0, 9) == 0) begin
                r.src = ALL_ONES - $urandom_range(0, 255);
            end
        end else begin
            s = $urandom_range(0, NUM_ST - 1);
            if (fill_cnt[s] != 0 && $urandom_range(0, 4) != 0) begin
                k   = $urandom_range(0, fill_cnt[s] - 1);
                off = (tab_len[s][k] == 0) ? '0 : $urandom % tab_len[s][k];
                if ($urandom_range(0, 9) == 0)
                    off = tab_len[s][k];    // one past the end
                r.seed = tab_src[s][k] + off;
            end
        end
        return r;
    endfunction

    task automatic send_req(input t_req r, input logic chk, input t_res typed);
        t_res p;
        req_if.valid        <= 1'b1;
        req_if.op           <= r.op;
        req_if.stage        <= r.stage;
        req_if.dest_start   <= r.dst;
        req_if.source_start <= r.src;
        req_if.range_length <= r.len;
        req_if.seed_value   <= r.seed;
        do @(posedge i_clk); while (!req_if.ready);
        p = remap_predict(r);
        pending_res_q.push_back(chk ? typed : p);
    endtask

    task automatic sender_gap();
        if (idle_en && $urandom_range(0, 7) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_res_q.size() != 0) @(posedge i_clk);
    endtask

    // Result side backpressure
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_chk
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_res_q.size() == 0) begin
                report_mismatch("result with nothing pending", res_if.final_value, '0);
            end else begin
                want = pending_res_q.pop_front();
                if (res_if.final_value !== want.final_value)
                    report_mismatch("final_value", res_if.final_value, want.final_value);
                if (res_if.lowest_value !== want.lowest_value)
                    report_mismatch("lowest_value", res_if.lowest_value, want.lowest_value);
                if (res_if.status !== want.status)
                    report_mismatch("status", FIELD_W'(res_if.status), FIELD_W'(want.status));
            end
        end
    end

    initial begin
        t_req             r;
        logic [STAGE_W-1:0] hot;
        t_res             no_res;

        for (int s = 0; s < NUM_ST; s++)
            fill_cnt[s] = 0;
        low_min = ALL_ONES;
        no_res  = '0;

        dir_tab = '{
            // empty tables: values pass straight through
            '{'{OP_XLATE, 3'd0, 32'h0, 32'h0, 32'h0, ALL_ONES}, 1'b1,
              '{ALL_ONES, ALL_ONES, STATUS_OK}},
            '{'{OP_NONE, 3'd7, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES}, 1'b1,
              '{32'h0, ALL_ONES, STATUS_OK}},
            '{'{OP_XLATE, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
              '{32'h0, 32'h0, STATUS_OK}},
            '{'{OP_CLEAR, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
              '{32'h0, ALL_ONES, STATUS_OK}},
            // stage index past the last table
            '{'{OP_LOAD, 3'd7, 32'h1, 32'h1, 32'h1, 32'h0}, 1'b1,
              '{32'h0, ALL_ONES, STATUS_FULL}},
            // zero-length entry never matches
            '{'{OP_LOAD, 3'd0, 32'd100, 32'd10, 32'h0, 32'h0}, 1'b1,
              '{32'h0, ALL_ONES, STATUS_OK}},
            '{'{OP_XLATE, 3'd0, 32'h0, 32'h0, 32'h0, 32'd10}, 1'b1,
              '{32'd10, 32'd10, STATUS_OK}},
            '{'{OP_LOAD, 3'd0, 32'hFFFF_FFF0, 32'h0, ALL_ONES, 32'h0}, 1'b1,
              '{32'h0, 32'd10, STATUS_OK}},
            '{'{OP_XLATE, 3'd0, 32'h0, 32'h0, 32'h0, 32'h20}, 1'b0, no_res},
            '{'{OP_XLATE, 3'd0, 32'h0, 32'h0, 32'h0, ALL_ONES}, 1'b0, no_res},
            '{'{OP_LOAD, 3'd6, 32'd5, ALL_ONES, 32'h1, 32'h0}, 1'b0, no_res},
            '{'{OP_XLATE, 3'd0, 32'h0, 32'h0, 32'h0, ALL_ONES}, 1'b0, no_res},
            // overlapping entries in one stage, the newer one wins
            '{'{OP_LOAD, 3'd3, 32'h1000, 32'h10, 32'h10, 32'h0}, 1'b0, no_res},
            '{'{OP_LOAD, 3'd3, 32'h2000, 32'h18, 32'h4, 32'h0}, 1'b0, no_res},
            '{'{OP_XLATE, 3'd0, 32'h0, 32'h0, 32'h0, 32'h29}, 1'b0, no_res},
            '{'{OP_XLATE, 3'd0, 32'h0, 32'h0, 32'h0, 32'h25}, 1'b0, no_res},
            '{'{OP_LOAD, 3'd4, 32'h0, 32'h2001, 32'h1, 32'h0}, 1'b0, no_res},
            '{'{OP_XLATE, 3'd0, 32'h0, 32'h0, 32'h0, 32'h29}, 1'b0, no_res},
            '{'{OP_CLEAR, 3'd5, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES}, 1'b1,
              '{32'h0, ALL_ONES, STATUS_OK}},
            '{'{OP_XLATE, 3'd0, 32'h0, 32'h0, 32'h0, 32'h29}, 1'b1,
              '{32'h29, 32'h29, STATUS_OK}},
            '{'{OP_LOAD, 3'd5, ALL_ONES, 32'h0, ALL_ONES, ALL_ONES}, 1'b1,
              '{32'h0, 32'h29, STATUS_OK}},
            '{'{OP_XLATE, 3'd1, ALL_ONES, ALL_ONES, ALL_ONES, 32'h1}, 1'b0, no_res},
            '{'{OP_NONE, 3'd2, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0, 32'h1234}, 1'b0, no_res}
        };

        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.op           <= OP_NONE;
        req_if.stage        <= '0;
        req_if.dest_start   <= '0;
        req_if.source_start <= '0;
        req_if.range_length <= '0;
        req_if.seed_value   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_en = 1'b1;
        foreach (dir_tab[i]) begin
            send_req(dir_tab[i].req, dir_tab[i].chk, dir_tab[i].res);
            sender_gap();
        end

        // fill one stage to capacity, then one load too many
        for (int n = 0; n <= DEPTH; n++) begin
            r.op    = OP_LOAD;
            r.stage = 3'd2;
            r.dst   = $urandom;
            r.src   = $urandom;
            r.len   = $urandom_range(0, 3);
            r.seed  = $urandom;
            send_req(r, 1'b0, no_res);
            sender_gap();
        end
        r.op   = OP_XLATE;
        r.seed = tab_src[2][0];
        send_req(r, 1'b0, no_res);
        r.op = OP_CLEAR;
        send_req(r, 1'b0, no_res);

        hot = '0;
        for (int n = 0; n < RAND_N; n++) begin
            idle_en = (n < RAND_N - 200) && ((n / 150) % 4 != 3);
            if (n == 300)
                hold_req = 1'b1;
            if (n == 700 || n == 1300)
                drain_results();
            r = gen_req(hot);
            if (r.op == OP_CLEAR)
                hot = STAGE_W'($urandom_range(0, NUM_ST - 1));
            send_req(r, 1'b0, no_res);
            sender_gap();
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && pending_res_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
